// ===== hdl/ordered_unique_list_engine_assert.svh =====
// Assertion macros for the ordered list engine.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef ORDERED_UNIQUE_LIST_ENGINE_ASSERT_SVH
`define ORDERED_UNIQUE_LIST_ENGINE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define OULE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ordered list engine: assertion failed");
`define OULE_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("ordered list engine: assertion failed");
`else
`define OULE_ASSERT(lbl, prop)
`define OULE_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== hdl/oule_pkg.sv =====
package oule_pkg;

  localparam int CAPACITY = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);

  localparam int VALUE_W  = 32;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 6;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 3;

  localparam int IN_TDATA_W  = ((VALUE_W + POS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((VALUE_W + COUNT_W + 7) / 8) * 8;

  // Wide enough to compare a position against count + 1 without overflow.
  localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  typedef logic signed [VALUE_W-1:0] value_t;

  localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_POS  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_HEAD = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_TAIL = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DEL_POS  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_READ     = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd4;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } cell_op_e;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    cell_op_e         op;
    logic [IDX_W-1:0] sel;
    logic [CNT_W-1:0] count;
    value_t           value;
  } cell_ctrl_t;

endpackage

// ===== hdl/oule_cell.sv =====
module oule_cell (
  input  logic                     clk_i,
  input  oule_pkg::cell_ctrl_t     ctrl_i,
  input  logic [oule_pkg::IDX_W-1:0] idx_i,
  input  oule_pkg::value_t         left_i,
  input  oule_pkg::value_t         right_i,
  input  oule_pkg::value_t         head_i,
  output oule_pkg::value_t         value_o,
  output logic                     match_o
);

  oule_pkg::value_t               value_d, value_q;
  logic [oule_pkg::CNT_W-1:0]     idx_ext;

  assign idx_ext = oule_pkg::CNT_W'(idx_i);

  always_comb begin
    value_d = value_q;
    case (ctrl_i.op)
      oule_pkg::CELL_INS: begin
        // open a gap at sel: cells past it take their left neighbor
        if (idx_i > ctrl_i.sel) begin
          value_d = left_i;
        end else if (idx_i == ctrl_i.sel) begin
          value_d = ctrl_i.value;
        end
      end
      oule_pkg::CELL_DEL: begin
        if (idx_i >= ctrl_i.sel) begin
          value_d = right_i;
        end
      end
      oule_pkg::CELL_ROT: begin
        // rotate the occupied part: the head value wraps around to the tail cell
        if ((idx_ext + oule_pkg::CNT_W'(1)) == ctrl_i.count) begin
          value_d = head_i;
        end else begin
          value_d = right_i;
        end
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign match_o = (value_q == ctrl_i.value) && (idx_ext < ctrl_i.count);

endmodule

// ===== hdl/oule_cell_chain.sv =====
module oule_cell_chain (
  input  logic                          clk_i,
  input  oule_pkg::cell_ctrl_t          ctrl_i,
  output oule_pkg::value_t              head_o,
  output logic [oule_pkg::CAPACITY-1:0] match_o
);

  oule_pkg::value_t cell_val [oule_pkg::CAPACITY];

  for (genvar i = 0; i < oule_pkg::CAPACITY; i++) begin : g_cell
    oule_pkg::value_t left_val, right_val;

    if (i == 0) begin : g_first
      assign left_val = ctrl_i.value;
    end else begin : g_mid_l
      assign left_val = cell_val[i-1];
    end

    if (i == oule_pkg::CAPACITY - 1) begin : g_last
      assign right_val = cell_val[0];
    end else begin : g_mid_r
      assign right_val = cell_val[i+1];
    end

    oule_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .idx_i   (oule_pkg::IDX_W'(i)),
      .left_i  (left_val),
      .right_i (right_val),
      .head_i  (cell_val[0]),
      .value_o (cell_val[i]),
      .match_o (match_o[i])
    );
  end

  assign head_o = cell_val[0];

endmodule

// ===== hdl/ordered_unique_list_engine.sv =====
// Channel   Dir  Fields (tuser | tdata low to high | tlast)
// s_axis    in   cmd | value, position | -
// m_axis    out  status | element, count | last
//
// Insert and delete are accepted in S_IDLE; in S_EXEC the cell row then compares for
// duplicates (on insert only) and shifts by one place.
// Readout is accepted in S_IDLE, starts in S_EXEC, then emits one element per cycle in S_READ
// while m_axis is free, the row rotating one place per element so its order is restored at the end.
// Reset clears the control state and the element count; cell contents stay undefined.
// A stalled m_axis holds the pending shift or rotation until the result slot frees.
`include "ordered_unique_list_engine_assert.svh"

module ordered_unique_list_engine (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [31:0] value, [37:32] position, upper bits zero
  input  logic [oule_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [2:0] cmd
  input  logic [oule_pkg::CMD_W-1:0]         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [31:0] element, [37:32] count, upper bits zero
  output logic [oule_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // [2:0] status
  output logic [oule_pkg::STATUS_W-1:0]      m_axis_tuser,
  output logic                               m_axis_tlast
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0]                      state_d, state_q;
  logic [oule_pkg::CMD_W-1:0]      cmd_d, cmd_q;
  oule_pkg::value_t                val_d, val_q;
  logic [oule_pkg::POS_W-1:0]      pos_d, pos_q;
  logic [oule_pkg::CNT_W-1:0]      count_d, count_q;
  logic [oule_pkg::CNT_W-1:0]      rd_left_d, rd_left_q;

  logic                            out_valid_d, out_valid_q;
  logic [oule_pkg::STATUS_W-1:0]   out_status_d, out_status_q;
  oule_pkg::value_t                out_elem_d, out_elem_q;
  logic [oule_pkg::COUNT_W-1:0]    out_count_d, out_count_q;
  logic                            out_last_d, out_last_q;

  oule_pkg::cell_ctrl_t            cell_ctrl;
  oule_pkg::value_t                head_val;
  logic [oule_pkg::CAPACITY-1:0]   match;

  logic                            out_free;
  logic                            emit;
  logic                            dup;
  logic                            full;
  logic                            ins_pos_ok;
  logic                            del_pos_ok;
  logic [oule_pkg::CMP_W-1:0]      pos_ext;
  logic [oule_pkg::CMP_W-1:0]      cnt_ext;
  logic [oule_pkg::IDX_W-1:0]      pos_idx;

  oule_cell_chain u_chain (
    .clk_i   (clk_i),
    .ctrl_i  (cell_ctrl),
    .head_o  (head_val),
    .match_o (match)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign out_free      = !out_valid_q || m_axis_tready;

  assign dup        = |match;
  assign full       = (count_q >= oule_pkg::CNT_W'(oule_pkg::CAPACITY));
  assign pos_ext    = oule_pkg::CMP_W'(pos_q);
  assign cnt_ext    = oule_pkg::CMP_W'(count_q);
  assign ins_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext + oule_pkg::CMP_W'(1));
  assign del_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign pos_idx    = oule_pkg::IDX_W'(pos_ext - oule_pkg::CMP_W'(1));

  always_comb begin
    state_d         = state_q;
    cmd_d           = cmd_q;
    val_d           = val_q;
    pos_d           = pos_q;
    count_d         = count_q;
    rd_left_d       = rd_left_q;
    emit            = 1'b0;
    out_status_d    = oule_pkg::ST_OK;
    out_elem_d      = '0;
    out_last_d      = 1'b1;
    cell_ctrl.op    = oule_pkg::CELL_HOLD;
    cell_ctrl.sel   = '0;
    cell_ctrl.count = count_q;
    cell_ctrl.value = val_q;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d   = s_axis_tuser;
          val_d   = oule_pkg::value_t'(s_axis_tdata[oule_pkg::VALUE_W-1:0]);
          pos_d   = s_axis_tdata[oule_pkg::VALUE_W +: oule_pkg::POS_W];
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (cmd_q) inside
          oule_pkg::CMD_INS_HEAD, oule_pkg::CMD_INS_TAIL, oule_pkg::CMD_INS_POS: begin
            if (out_free) begin
              emit    = 1'b1;
              state_d = S_IDLE;
              if (dup) begin
                out_status_d = oule_pkg::ST_DUP;
              end else if (full) begin
                out_status_d = oule_pkg::ST_FULL;
              end else if ((cmd_q == oule_pkg::CMD_INS_POS) && !ins_pos_ok) begin
                out_status_d = oule_pkg::ST_BADPOS;
              end else begin
                cell_ctrl.op = oule_pkg::CELL_INS;
                if (cmd_q == oule_pkg::CMD_INS_HEAD) begin
                  cell_ctrl.sel = '0;
                end else if (cmd_q == oule_pkg::CMD_INS_TAIL) begin
                  cell_ctrl.sel = oule_pkg::IDX_W'(count_q);
                end else begin
                  cell_ctrl.sel = pos_idx;
                end
                count_d = count_q + oule_pkg::CNT_W'(1);
              end
            end
          end
          oule_pkg::CMD_DEL_HEAD, oule_pkg::CMD_DEL_TAIL, oule_pkg::CMD_DEL_POS: begin
            if (out_free) begin
              emit    = 1'b1;
              state_d = S_IDLE;
              if (count_q == '0) begin
                out_status_d = oule_pkg::ST_EMPTY;
              end else if ((cmd_q == oule_pkg::CMD_DEL_POS) && !del_pos_ok) begin
                out_status_d = oule_pkg::ST_BADPOS;
              end else begin
                cell_ctrl.op = oule_pkg::CELL_DEL;
                if (cmd_q == oule_pkg::CMD_DEL_HEAD) begin
                  cell_ctrl.sel = '0;
                end else if (cmd_q == oule_pkg::CMD_DEL_TAIL) begin
                  cell_ctrl.sel = oule_pkg::IDX_W'(count_q - oule_pkg::CNT_W'(1));
                end else begin
                  cell_ctrl.sel = pos_idx;
                end
                count_d = count_q - oule_pkg::CNT_W'(1);
              end
            end
          end
          oule_pkg::CMD_READ: begin
            if (count_q == '0) begin
              if (out_free) begin
                emit         = 1'b1;
                out_status_d = oule_pkg::ST_EMPTY;
                state_d      = S_IDLE;
              end
            end else begin
              rd_left_d = count_q;
              state_d   = S_READ;
            end
          end
          default: begin
            // unused command: drop it
            state_d = S_IDLE;
          end
        endcase
      end
      S_READ: begin
        if (out_free) begin
          emit         = 1'b1;
          out_elem_d   = head_val;
          out_last_d   = (rd_left_q == oule_pkg::CNT_W'(1));
          cell_ctrl.op = oule_pkg::CELL_ROT;
          rd_left_d    = rd_left_q - oule_pkg::CNT_W'(1);
          if (rd_left_q == oule_pkg::CNT_W'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    out_count_d = oule_pkg::COUNT_W'(count_d);

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_left_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_left_q   <= rd_left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    val_q <= val_d;
    pos_q <= pos_d;
    if (emit) begin
      out_status_q <= out_status_d;
      out_elem_q   <= out_elem_d;
      out_count_q  <= out_count_d;
      out_last_q   <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {{(oule_pkg::OUT_TDATA_W - oule_pkg::VALUE_W - oule_pkg::COUNT_W){1'b0}},
                          out_count_q, out_elem_q};

  `OULE_ASSERT(a_count_bound, count_q <= oule_pkg::CNT_W'(oule_pkg::CAPACITY))
  `OULE_ASSERT(a_count_step,
               (count_q == $past(count_q)) ||
               (count_q == $past(count_q) + oule_pkg::CNT_W'(1)) ||
               (count_q + oule_pkg::CNT_W'(1) == $past(count_q)))
  `OULE_ASSERT(a_read_count_stable, (state_q == S_READ) |-> $stable(count_q))
  `OULE_ASSERT_NEXT(a_read_ends,
                    (state_q == S_READ) && (rd_left_q == oule_pkg::CNT_W'(1)) && out_free,
                    state_q == S_IDLE)

endmodule
